[hw/rtl/ikpv_pkg.sv]
// ----------------------------------------------------------------------------
// ikpv_pkg: shared types, constants and step functions
// Widths, latencies and the digit steps of the root and divide pipelines.
// ----------------------------------------------------------------------------
package ikpv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CW         = 33;             // difference vector component
  localparam int DW         = FRAC_BITS + 2;  // unit direction component
  localparam int SQ_STAGES  = 16;             // two root bits per stage
  localparam int DIV_STAGES = 9;              // two quotient bits per stage
  localparam int QW         = 2 * DIV_STAGES;
  localparam int UNIT_LAT   = 4 + SQ_STAGES + 1 + DIV_STAGES + 1;
  localparam int TOTAL_LAT  = 3 + UNIT_LAT + 8 + UNIT_LAT + 1;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [DW-1:0] dir_t;

  typedef enum logic {
    REG_ZERO_TOL = 1'b0,
    REG_NORM_TOL = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [30:0]   rem;
    logic [QW-1:0] quo;
  } dv_t;

  // one bit of an integer square root
  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
    logic [35:0] r;
    logic [35:0] t;
    sq_t o;
    r = {s.rem, pair};
    t = {2'b00, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = 34'(r - t);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of a restoring division
  function automatic dv_t div_step(dv_t s, logic nb, logic [30:0] d);
    logic [31:0] t;
    dv_t o;
    t = {s.rem, nb};
    if (t >= {1'b0, d}) begin
      o.rem = 31'(t - {1'b0, d});
      o.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = t[30:0];
      o.quo = {s.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[hw/rtl/ikpv_unit.sv]
// ----------------------------------------------------------------------------
// ikpv_unit: pipelined unit vector
// Normalizes the magnitude, squares and sums, takes the root and divides
// each component by the length. Fixed latency, advances on en_i.
// ----------------------------------------------------------------------------
module ikpv_unit (
  input  logic             clk_i,
  input  logic             en_i,
  input  ikpv_pkg::comp_t  vec_i [3],
  output ikpv_pkg::dir_t   dir_o [3]
);

  localparam int SQ = ikpv_pkg::SQ_STAGES;
  localparam int DV = ikpv_pkg::DIV_STAGES;
  localparam int QW = ikpv_pkg::QW;
  localparam int FB = ikpv_pkg::FRAC_BITS;

  typedef struct packed {
    logic [2:0][29:0] mn;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } sgn_t;

  // stage 1: magnitudes
  logic [32:0] mag1_q [3];
  logic [2:0]  neg1_q;
  logic [32:0] top1_q;
  logic [32:0] mag1_d [3];
  logic [32:0] top1_d;

  always_comb begin
    top1_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][32] ? 33'(-vec_i[i]) : 33'(vec_i[i]);
      if (mag1_d[i] > top1_d) top1_d = mag1_d[i];
    end
  end

  // stage 2: put the largest magnitude in [2^29, 2^30)
  side_t      side2_d, side2_q, side3_q, side4_q;
  logic [5:0] msb2;
  logic [32:0] sh2 [3];

  always_comb begin
    msb2 = '0;
    for (int k = 0; k < 33; k++) begin
      if (top1_q[k]) msb2 = 6'(k);
    end
    side2_d.neg  = neg1_q;
    side2_d.zero = (top1_q == '0);
    for (int i = 0; i < 3; i++) begin
      sh2[i] = (msb2 >= 6'd29) ? (mag1_q[i] >> (msb2 - 6'd29))
                               : (mag1_q[i] << (6'd29 - msb2));
      side2_d.mn[i] = sh2[i][29:0];
    end
  end

  // stages 3 and 4: squares, sum
  logic [59:0] sq3_q [3];
  logic [61:0] sum4_q;

  // root pipeline over the 62-bit sum, top pair first
  ikpv_pkg::sq_t sst_q  [SQ];
  logic [63:0]   sx_q   [SQ];
  side_t         sside_q[SQ];
  ikpv_pkg::sq_t sst_d  [SQ];
  logic [63:0]   sx_d   [SQ];
  ikpv_pkg::sq_t st_tmp [SQ];

  always_comb begin
    st_tmp[0] = ikpv_pkg::sqrt_step('0, 2'b00);
    sst_d[0]  = ikpv_pkg::sqrt_step(st_tmp[0], sum4_q[61:60]);
    sx_d[0]   = {2'b00, sum4_q} << 4;
    for (int j = 1; j < SQ; j++) begin
      st_tmp[j] = ikpv_pkg::sqrt_step(sst_q[j-1], sx_q[j-1][63:62]);
      sst_d[j]  = ikpv_pkg::sqrt_step(st_tmp[j], sx_q[j-1][61:60]);
      sx_d[j]   = sx_q[j-1] << 4;
    end
  end

  // divide setup: (m * 2^FB + len / 2) / len
  logic [46:0] num0 [3];
  ikpv_pkg::dv_t dv0_q [3];
  logic [QW-1:0] nlo0_q [3];
  logic [30:0]   dd0_q;
  sgn_t          sg0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num0[i] = {1'b0, sside_q[SQ-1].mn[i], {FB{1'b0}}}
              + 47'(sst_q[SQ-1].root >> 1);
    end
  end

  // divide pipeline
  ikpv_pkg::dv_t dv_q   [DV][3];
  logic [QW-1:0] nlo_q  [DV][3];
  logic [30:0]   dd_q   [DV];
  sgn_t          dsg_q  [DV];
  ikpv_pkg::dv_t dv_d   [DV][3];
  ikpv_pkg::dv_t dv_tmp [DV][3];
  logic [QW-1:0] nlo_d  [DV][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_tmp[0][i] = ikpv_pkg::div_step(dv0_q[i], nlo0_q[i][QW-1], dd0_q);
      dv_d[0][i]   = ikpv_pkg::div_step(dv_tmp[0][i], nlo0_q[i][QW-2], dd0_q);
      nlo_d[0][i]  = nlo0_q[i] << 2;
      for (int j = 1; j < DV; j++) begin
        dv_tmp[j][i] = ikpv_pkg::div_step(dv_q[j-1][i], nlo_q[j-1][i][QW-1], dd_q[j-1]);
        dv_d[j][i]   = ikpv_pkg::div_step(dv_tmp[j][i], nlo_q[j-1][i][QW-2], dd_q[j-1]);
        nlo_d[j][i]  = nlo_q[j-1][i] << 2;
      end
    end
  end

  // output: clamp, sign
  logic [QW-1:0]   q_o [3];
  ikpv_pkg::dir_t  dir_d [3];
  ikpv_pkg::dir_t  dir_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_o[i] = dv_q[DV-1][i].quo;
      if (q_o[i] > (QW'(1) << FB)) q_o[i] = QW'(1) << FB;
      if (dsg_q[DV-1].zero) begin
        dir_d[i] = '0;
      end else if (dsg_q[DV-1].neg[i]) begin
        dir_d[i] = -ikpv_pkg::dir_t'(q_o[i]);
      end else begin
        dir_d[i] = ikpv_pkg::dir_t'(q_o[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag1_d[i];
        neg1_q[i] <= vec_i[i][32];
        sq3_q[i]  <= {30'b0, side2_q.mn[i]} * {30'b0, side2_q.mn[i]};
      end
      top1_q  <= top1_d;
      side2_q <= side2_d;
      side3_q <= side2_q;
      sum4_q  <= 62'(sq3_q[0]) + 62'(sq3_q[1]) + 62'(sq3_q[2]);
      side4_q <= side3_q;
      sst_q[0]   <= sst_d[0];
      sx_q[0]    <= sx_d[0];
      sside_q[0] <= side4_q;
      for (int j = 1; j < SQ; j++) begin
        sst_q[j]   <= sst_d[j];
        sx_q[j]    <= sx_d[j];
        sside_q[j] <= sside_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        dv0_q[i].rem <= {2'b00, num0[i][46:QW]};
        dv0_q[i].quo <= '0;
        nlo0_q[i]    <= num0[i][QW-1:0];
      end
      dd0_q      <= sst_q[SQ-1].root[30:0];
      sg0_q.neg  <= sside_q[SQ-1].neg;
      sg0_q.zero <= sside_q[SQ-1].zero;
      dd_q[0]  <= dd0_q;
      dsg_q[0] <= sg0_q;
      for (int j = 1; j < DV; j++) begin
        dd_q[j]  <= dd_q[j-1];
        dsg_q[j] <= dsg_q[j-1];
      end
      for (int j = 0; j < DV; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_q[j][i]  <= dv_d[j][i];
          nlo_q[j][i] <= nlo_d[j][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= dir_d[i];
      end
    end
  end

  assign dir_o = dir_q;

endmodule

[hw/rtl/ik_pole_vector_core.sv]
// ----------------------------------------------------------------------------
// ik_pole_vector_core: pole vector projection for a two-bone chain
// One beat per cycle while the output accepts. Two unit-vector pipelines
// (16 root stages and 9 divide stages each) set the depth.
// The pipeline holds on output backpressure.
// Reset clears the valid chain and loads the tolerances (7 and 43).
// ----------------------------------------------------------------------------
module ik_pole_vector_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,  // proj_x proj_y proj_z dir_x dir_y dir_z, pad
  output logic         m_axis_tuser,  // ok
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int UL = ikpv_pkg::UNIT_LAT;
  localparam int TL = ikpv_pkg::TOTAL_LAT;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][32:0] ab;
    logic             tiny;
    logic             ac_short;
  } sb1_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][17:0] n;
    logic             tiny;
    logic             ac_short;
  } sbp_t;

  typedef struct packed {
    logic [2:0][31:0] proj;
    logic [2:0][17:0] vraw;
    logic [2:0][17:0] n;
    logic             tiny;
    logic             ac_short;
    logic             vlong;
  } sb3_t;

  // configuration
  logic [15:0] ztol_q;
  logic [31:0] ntol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ztol_q <= 16'd7;
      ntol_q <= 32'd43;
    end else if (cfg_we_i) begin
      unique case (ikpv_pkg::reg_idx_e'(cfg_idx_i))
        ikpv_pkg::REG_ZERO_TOL: ztol_q <= cfg_data_i[15:0];
        ikpv_pkg::REG_NORM_TOL: ntol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid chain
  logic [TL-1:0] vld_q;
  logic          adv;

  assign adv           = ~vld_q[TL-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[TL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TL-2:0], s_axis_tvalid};
    end
  end

  // stage 1: differences and the zero test
  logic signed [31:0] a_c [3];
  logic signed [31:0] b_c [3];
  logic signed [31:0] c_c [3];
  ikpv_pkg::comp_t    ab_c [3];
  ikpv_pkg::comp_t    ac_c [3];
  logic [32:0]        abm_c [3];
  logic               tiny_c;

  always_comb begin
    tiny_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      a_c[i]  = s_axis_tdata[32*i +: 32];
      b_c[i]  = s_axis_tdata[32*(3+i) +: 32];
      c_c[i]  = s_axis_tdata[32*(6+i) +: 32];
      ab_c[i] = ikpv_pkg::comp_t'(b_c[i]) - ikpv_pkg::comp_t'(a_c[i]);
      ac_c[i] = ikpv_pkg::comp_t'(c_c[i]) - ikpv_pkg::comp_t'(a_c[i]);
      abm_c[i] = ab_c[i][32] ? 33'(-ab_c[i]) : 33'(ab_c[i]);
      if (abm_c[i] > {17'b0, ztol_q}) tiny_c = 1'b0;
    end
  end

  sb1_t            s1_q, s2_q, s3_q;
  sb1_t            s3_d;
  ikpv_pkg::comp_t ac1_q [3];
  ikpv_pkg::comp_t ac2_q [3];
  ikpv_pkg::comp_t ac3_q [3];
  logic [63:0]     acsq2_q [3];
  logic [32:0]     acm1 [3];
  logic [65:0]     acsum2;

  always_comb begin
    acsum2 = '0;
    for (int i = 0; i < 3; i++) begin
      acm1[i] = ac1_q[i][32] ? 33'(-ac1_q[i]) : 33'(ac1_q[i]);
      acsum2  = acsum2 + 66'(acsq2_q[i]);
    end
    s3_d          = s2_q;
    s3_d.ac_short = (acsum2 <= 66'(ntol_q));
  end

  // unit vector of AB (short AC) or of AC
  ikpv_pkg::comp_t u1_in [3];
  ikpv_pkg::dir_t  u1_dir [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u1_in[i] = s3_q.ac_short ? ikpv_pkg::comp_t'(s3_q.ab[i]) : ac3_q[i];
    end
  end

  ikpv_unit u_unit_n (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (u1_in),
    .dir_o (u1_dir)
  );

  sb1_t dl1_q [UL];
  sb1_t sb1_o;
  assign sb1_o = dl1_q[UL-1];

  // projection stages
  sbp_t               p1_q, p2_q, p3_q, p4_q;
  logic signed [50:0] pr1_q [3];
  logic signed [52:0] dot2;
  logic [52:0]        dotm2;
  logic [36:0]        dr2;
  logic signed [37:0] d2_q;
  logic signed [55:0] dn3_q [3];
  logic [55:0]        dnm4 [3];
  logic [39:0]        offr4 [3];
  logic signed [40:0] off4_q [3];
  logic signed [41:0] ps5 [3];
  logic signed [31:0] proj5_d [3];
  logic signed [31:0] proj5_q [3];
  sbp_t               p5_q;
  ikpv_pkg::comp_t    v6_q [3];
  logic signed [31:0] proj6_q [3];
  sbp_t               p6_q;
  logic [32:0]        vm6 [3];
  logic [63:0]        vsq7_q [3];
  ikpv_pkg::comp_t    v7_q [3];
  logic signed [31:0] proj7_q [3];
  sbp_t               p7_q;
  logic [65:0]        vsum7;
  ikpv_pkg::comp_t    v8_q [3];
  logic signed [31:0] proj8_q [3];
  sbp_t               p8_q;
  logic               vlong8_q;
  sbp_t               p1_d;

  always_comb begin
    p1_d.a        = sb1_o.a;
    p1_d.b        = sb1_o.b;
    p1_d.tiny     = sb1_o.tiny;
    p1_d.ac_short = sb1_o.ac_short;
    for (int i = 0; i < 3; i++) begin
      p1_d.n[i] = u1_dir[i];
    end
    // dot product, rounded half away from zero
    dot2  = 53'(pr1_q[0]) + 53'(pr1_q[1]) + 53'(pr1_q[2]);
    dotm2 = dot2[52] ? 53'(-dot2) : 53'(dot2);
    dr2   = 37'((dotm2 + 53'(1 << (ikpv_pkg::FRAC_BITS - 1))) >> ikpv_pkg::FRAC_BITS);
    vsum7 = '0;
    for (int i = 0; i < 3; i++) begin
      dnm4[i]  = dn3_q[i][55] ? 56'(-dn3_q[i]) : 56'(dn3_q[i]);
      offr4[i] = 40'((dnm4[i] + 56'(1 << (ikpv_pkg::FRAC_BITS - 1)))
                     >> ikpv_pkg::FRAC_BITS);
      ps5[i]   = 42'($signed(p4_q.a[i])) + 42'(off4_q[i]);
      if (p4_q.tiny || p4_q.ac_short) begin
        proj5_d[i] = $signed(p4_q.a[i]);
      end else if (ps5[i] > 42'sh0007fffffff) begin
        proj5_d[i] = 32'sh7fffffff;
      end else if (ps5[i] < -42'sh00080000000) begin
        proj5_d[i] = 32'sh80000000;
      end else begin
        proj5_d[i] = ps5[i][31:0];
      end
      vm6[i] = v6_q[i][32] ? 33'(-v6_q[i]) : 33'(v6_q[i]);
      vsum7  = vsum7 + 66'(vsq7_q[i]);
    end
  end

  // second unit vector: B minus projection
  ikpv_pkg::dir_t u2_dir [3];

  ikpv_unit u_unit_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (v8_q),
    .dir_o (u2_dir)
  );

  sb3_t dl3_q [UL];
  sb3_t sb3_d;
  sb3_t sb3_o;
  assign sb3_o = dl3_q[UL-1];

  always_comb begin
    sb3_d.tiny     = p8_q.tiny;
    sb3_d.ac_short = p8_q.ac_short;
    sb3_d.vlong    = vlong8_q;
    sb3_d.n        = p8_q.n;
    for (int i = 0; i < 3; i++) begin
      sb3_d.proj[i] = proj8_q[i];
      sb3_d.vraw[i] = v8_q[i][17:0];
    end
  end

  // output select
  logic [31:0]    proj_q [3];
  ikpv_pkg::dir_t dir_q  [3];
  logic           ok_q;
  ikpv_pkg::dir_t dir_d  [3];
  logic           ok_d;

  always_comb begin
    priority if (sb3_o.tiny) begin
      ok_d = 1'b0;
      for (int i = 0; i < 3; i++) dir_d[i] = '0;
    end else if (sb3_o.ac_short) begin
      ok_d = 1'b1;
      for (int i = 0; i < 3; i++) dir_d[i] = sb3_o.n[i];
    end else if (sb3_o.vlong) begin
      ok_d = 1'b1;
      for (int i = 0; i < 3; i++) dir_d[i] = u2_dir[i];
    end else begin
      ok_d = 1'b0;
      for (int i = 0; i < 3; i++) dir_d[i] = sb3_o.vraw[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_q.a[i]  <= a_c[i];
        s1_q.b[i]  <= b_c[i];
        s1_q.ab[i] <= ab_c[i];
        ac1_q[i]   <= ac_c[i];
        ac2_q[i]   <= ac1_q[i];
        ac3_q[i]   <= ac2_q[i];
        acsq2_q[i] <= {32'b0, acm1[i][31:0]} * {32'b0, acm1[i][31:0]};
      end
      s1_q.tiny     <= tiny_c;
      s1_q.ac_short <= 1'b0;
      s2_q          <= s1_q;
      s3_q          <= s3_d;
      dl1_q[0] <= s3_q;
      for (int k = 1; k < UL; k++) dl1_q[k] <= dl1_q[k-1];
      // projection
      p1_q <= p1_d;
      for (int i = 0; i < 3; i++) begin
        pr1_q[i] <= ikpv_pkg::comp_t'(sb1_o.ab[i]) * u1_dir[i];
      end
      p2_q <= p1_q;
      d2_q <= dot2[52] ? -38'(dr2) : 38'(dr2);
      p3_q <= p2_q;
      for (int i = 0; i < 3; i++) begin
        dn3_q[i]  <= d2_q * $signed(p2_q.n[i]);
        off4_q[i] <= dn3_q[i][55] ? -41'(offr4[i]) : 41'(offr4[i]);
        proj5_q[i] <= proj5_d[i];
        v6_q[i]    <= ikpv_pkg::comp_t'($signed(p5_q.b[i]))
                    - ikpv_pkg::comp_t'(proj5_q[i]);
        proj6_q[i] <= proj5_q[i];
        vsq7_q[i]  <= {32'b0, vm6[i][31:0]} * {32'b0, vm6[i][31:0]};
        v7_q[i]    <= v6_q[i];
        proj7_q[i] <= proj6_q[i];
        v8_q[i]    <= v7_q[i];
        proj8_q[i] <= proj7_q[i];
      end
      p4_q <= p3_q;
      p5_q <= p4_q;
      p6_q <= p5_q;
      p7_q <= p6_q;
      p8_q <= p7_q;
      vlong8_q <= (vsum7 > 66'(ntol_q));
      dl3_q[0] <= sb3_d;
      for (int k = 1; k < UL; k++) dl3_q[k] <= dl3_q[k-1];
      for (int i = 0; i < 3; i++) begin
        proj_q[i] <= sb3_o.proj[i];
        dir_q[i]  <= dir_d[i];
      end
      ok_q <= ok_d;
    end
  end

  assign m_axis_tdata = {2'b00, dir_q[2], dir_q[1], dir_q[0],
                         proj_q[2], proj_q[1], proj_q[0]};
  assign m_axis_tuser = ok_q;

endmodule
